>>> design/lps_pkg.sv
package lps_pkg;

	// Fixed field widths of the stream words.
	localparam int DEPTH_W    = 3;
	localparam int TAG_W      = 8;
	localparam int FIELD_BITS = 16;
	localparam int IN_LEVELS  = 4;
	localparam int TDATA_W    = 80;

	// Control broadcast from the top level to every cell of the chain.
	typedef struct packed {
		logic load;   // a record is being inserted this cycle
		logic emit;   // the head word is taken, the chain moves toward cell zero
	} cell_ctrl_t;

endpackage

>>> design/lps_cell.sv
module lps_cell #(
	parameter int LEVEL_BITS = 16,
	parameter int NLV        = 4
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  lps_pkg::cell_ctrl_t                    ctrl,
	input  logic [lps_pkg::DEPTH_W-1:0]            new_depth,
	input  logic [NLV-1:0][LEVEL_BITS-1:0]         new_levels,
	input  logic [lps_pkg::TAG_W-1:0]              new_tag,
	input  logic                                   prev_valid,
	input  logic                                   prev_shift,
	input  logic [lps_pkg::DEPTH_W-1:0]            prev_depth,
	input  logic [NLV-1:0][LEVEL_BITS-1:0]         prev_levels,
	input  logic [lps_pkg::TAG_W-1:0]              prev_tag,
	input  logic                                   next_valid,
	input  logic [lps_pkg::DEPTH_W-1:0]            next_depth,
	input  logic [NLV-1:0][LEVEL_BITS-1:0]         next_levels,
	input  logic [lps_pkg::TAG_W-1:0]              next_tag,
	output logic                                   valid,
	output logic                                   shift,
	output logic [lps_pkg::DEPTH_W-1:0]            depth,
	output logic [NLV-1:0][LEVEL_BITS-1:0]         levels,
	output logic [lps_pkg::TAG_W-1:0]              tag
);

	logic                               valid_q;
	logic [lps_pkg::DEPTH_W-1:0]        depth_q;
	logic [NLV-1:0][LEVEL_BITS-1:0]     levels_q;
	logic [lps_pkg::TAG_W-1:0]          tag_q;
	logic [lps_pkg::DEPTH_W-1:0]        common;
	logic                               after;
	logic                               take;

	// The held record sorts strictly after the new one. Equal paths never
	// move, so a new record lands behind its equals and the order is stable.
	always_comb begin
		common = (depth_q < new_depth) ? depth_q : new_depth;
		after  = depth_q > new_depth;
		for (int e = NLV - 1; e >= 0; e--) begin
			if ((lps_pkg::DEPTH_W'(e) < common) && (levels_q[e] != new_levels[e])) begin
				after = $signed(levels_q[e]) > $signed(new_levels[e]);
			end
		end
	end

	assign shift = valid_q && after;
	// Take a record when this one moves down, or when this is the first free cell.
	assign take  = shift || (!valid_q && prev_valid);

	// Valid flag of the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			valid_q <= next_valid;
		end else if (ctrl.load) begin
			valid_q <= valid_q | prev_valid;
		end
	end

	// Record held by the cell.
	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			depth_q  <= next_depth;
			levels_q <= next_levels;
			tag_q    <= next_tag;
		end else if (ctrl.load && take) begin
			if (prev_shift) begin
				depth_q  <= prev_depth;
				levels_q <= prev_levels;
				tag_q    <= prev_tag;
			end else begin
				depth_q  <= new_depth;
				levels_q <= new_levels;
				tag_q    <= new_tag;
			end
		end
	end

	assign valid  = valid_q;
	assign depth  = depth_q;
	assign levels = levels_q;
	assign tag    = tag_q;

endmodule

>>> design/lexicographic_path_sorter.sv
// Stable sorter for hierarchical key paths. Records enter on the slave stream,
// one word per cycle, and are inserted at once into a chain of CAPACITY cells
// that always holds them in ascending lexicographic order; a path that is a
// prefix of another sorts first and equal paths keep their load order. The
// word with tlast set is inserted like any other and then starts the drain:
// the held records leave on the master stream, smallest first, one word per
// cycle while tready is high, with tlast on the final one. s_tready stays low
// during the drain. Every cell compares the incoming record with its own in
// the load cycle, and the chain moves one place toward the output per word
// taken. A record that arrives while all cells are full is dropped and tuser
// is set on every word of that run.
module lexicographic_path_sorter #(
	parameter int CAPACITY   = 16,
	parameter int MAX_LEVELS = 4,
	parameter int LEVEL_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// path_depth[2:0], key_level_zero, key_level_one, key_level_two,
	// key_level_three (16 bits each), record_tag[7:0], zero fill
	input  logic [lps_pkg::TDATA_W-1:0]   s_tdata,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// out_depth[2:0], out_level_zero, out_level_one, out_level_two,
	// out_level_three (16 bits each), out_tag[7:0], zero fill
	output logic [lps_pkg::TDATA_W-1:0]   m_tdata,
	// overflowed
	output logic                          m_tuser,
	output logic                          m_tlast
);

	localparam int NLV = (MAX_LEVELS < lps_pkg::IN_LEVELS) ? MAX_LEVELS : lps_pkg::IN_LEVELS;
	localparam int DW  = lps_pkg::DEPTH_W;
	localparam int TW  = lps_pkg::TAG_W;
	localparam int FB  = lps_pkg::FIELD_BITS;
	localparam int TAG_LSB = DW + lps_pkg::IN_LEVELS * FB;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	state_t                         state_q;
	logic                           ovf_q;
	lps_pkg::cell_ctrl_t            ctrl;
	logic                           in_word;
	logic                           out_word;
	logic                           full;

	logic [DW-1:0]                  raw_depth;
	logic [DW-1:0]                  new_depth;
	logic [NLV-1:0][LEVEL_BITS-1:0] new_levels;
	logic [TW-1:0]                  new_tag;

	logic                           c_valid  [CAPACITY];
	logic                           c_shift  [CAPACITY];
	logic [DW-1:0]                  c_depth  [CAPACITY];
	logic [NLV-1:0][LEVEL_BITS-1:0] c_levels [CAPACITY];
	logic [TW-1:0]                  c_tag    [CAPACITY];

	logic [NLV-1:0][FB-1:0]           m_tdata_lv;
	logic [lps_pkg::IN_LEVELS*FB-1:0] out_levels;

	assign in_word  = s_tvalid && s_tready;
	assign out_word = m_tvalid && m_tready;
	assign full     = c_valid[CAPACITY-1];
	assign ctrl.load = in_word && !full;
	assign ctrl.emit = out_word;

	// Depth is clamped to one level at least and MAX_LEVELS at most.
	assign raw_depth = s_tdata[DW-1:0];
	always_comb begin
		if (raw_depth == '0) begin
			new_depth = DW'(1);
		end else if (int'(raw_depth) > MAX_LEVELS) begin
			new_depth = DW'(MAX_LEVELS);
		end else begin
			new_depth = raw_depth;
		end
	end
	assign new_tag = s_tdata[TAG_LSB +: TW];

	// Levels beyond the depth are stored as zero.
	for (genvar l = 0; l < NLV; l++) begin : g_in_level
		logic [LEVEL_BITS-1:0] lv;
		if (LEVEL_BITS <= FB) begin : g_narrow
			assign lv = s_tdata[DW + l*FB +: LEVEL_BITS];
		end else begin : g_wide
			assign lv = {{(LEVEL_BITS-FB){1'b0}}, s_tdata[DW + l*FB +: FB]};
		end
		assign new_levels[l] = (DW'(l) < new_depth) ? lv : '0;
	end

	// The chain of cells; cell zero holds the smallest record.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                           p_valid;
		logic                           p_shift;
		logic [DW-1:0]                  p_depth;
		logic [NLV-1:0][LEVEL_BITS-1:0] p_levels;
		logic [TW-1:0]                  p_tag;
		logic                           n_valid;
		logic [DW-1:0]                  n_depth;
		logic [NLV-1:0][LEVEL_BITS-1:0] n_levels;
		logic [TW-1:0]                  n_tag;

		if (i == 0) begin : g_head
			assign p_valid  = 1'b1;
			assign p_shift  = 1'b0;
			assign p_depth  = '0;
			assign p_levels = '0;
			assign p_tag    = '0;
		end else begin : g_body
			assign p_valid  = c_valid[i-1];
			assign p_shift  = c_shift[i-1];
			assign p_depth  = c_depth[i-1];
			assign p_levels = c_levels[i-1];
			assign p_tag    = c_tag[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign n_valid  = 1'b0;
			assign n_depth  = '0;
			assign n_levels = '0;
			assign n_tag    = '0;
		end else begin : g_link
			assign n_valid  = c_valid[i+1];
			assign n_depth  = c_depth[i+1];
			assign n_levels = c_levels[i+1];
			assign n_tag    = c_tag[i+1];
		end

		lps_cell #(
			.LEVEL_BITS (LEVEL_BITS),
			.NLV        (NLV)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_depth   (new_depth),
			.new_levels  (new_levels),
			.new_tag     (new_tag),
			.prev_valid  (p_valid),
			.prev_shift  (p_shift),
			.prev_depth  (p_depth),
			.prev_levels (p_levels),
			.prev_tag    (p_tag),
			.next_valid  (n_valid),
			.next_depth  (n_depth),
			.next_levels (n_levels),
			.next_tag    (n_tag),
			.valid       (c_valid[i]),
			.shift       (c_shift[i]),
			.depth       (c_depth[i]),
			.levels      (c_levels[i]),
			.tag         (c_tag[i])
		);
	end

	// Load and drain control with the overflow flag of the current run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_word) begin
						if (full) begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (out_word && !c_valid[1]) begin
						state_q <= ST_LOAD;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_LOAD);
	assign m_tvalid = (state_q == ST_DRAIN);
	assign m_tuser  = ovf_q;
	assign m_tlast  = !c_valid[1];

	// Output word from the head cell.
	always_comb begin
		m_tdata = '0;
		m_tdata[DW-1:0] = c_depth[0];
		m_tdata[DW +: lps_pkg::IN_LEVELS*FB] = out_levels;
		m_tdata[TAG_LSB +: TW] = c_tag[0];
	end

	for (genvar l = 0; l < NLV; l++) begin : g_out_level
		logic [FB-1:0] ov;
		if (LEVEL_BITS >= FB) begin : g_wide
			assign ov = c_levels[0][l][FB-1:0];
		end else begin : g_narrow
			assign ov = {{(FB-LEVEL_BITS){1'b0}}, c_levels[0][l]};
		end
		assign m_tdata_lv[l] = ov;
	end

	always_comb begin
		out_levels = '0;
		for (int l = 0; l < NLV; l++) begin
			out_levels[l*FB +: FB] = m_tdata_lv[l];
		end
	end

endmodule
